// ===== rtl/core/elfr_pkg.sv =====
// Shared types and constants for the escaped line frame receiver.
`default_nettype none

package elfr_pkg;

   localparam int DEF_BUF_DEPTH = 1024;
   localparam int BYTE_W        = 8;
   localparam int FRAME_LEN_W   = 10;
   localparam int IDX_W         = 10;
   localparam int MODE_W        = 2;
   localparam int QUEUE_DEPTH   = 4;
   localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

   localparam logic [MODE_W-1:0] MODE_LINK    = 2'd0;
   localparam logic [MODE_W-1:0] MODE_READ    = 2'd1;
   localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd2;

   localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'h0A;
   localparam logic [BYTE_W-1:0] CH_RETURN  = 8'h0D;
   localparam logic [BYTE_W-1:0] CH_ESCAPE  = 8'h10;

   typedef enum logic [2:0] {
      ST_STORED   = 3'd0,
      ST_ESC      = 3'd1,
      ST_DONE     = 3'd2,
      ST_RESTART  = 3'd3,
      ST_OVERFLOW = 3'd4,
      ST_NOTREADY = 3'd5,
      ST_READ     = 3'd6,
      ST_RELEASED = 3'd7
   } status_type;

   // Classified item leaving the front stage.
   typedef struct packed {
      status_type             status;
      logic [FRAME_LEN_W-1:0] frame_length;
      logic                   rd_en;
   } front_entry_type;

   // Finished result held in the response queue.
   typedef struct packed {
      status_type             status;
      logic [FRAME_LEN_W-1:0] frame_length;
      logic [BYTE_W-1:0]      read_byte;
   } rsp_entry_type;

endpackage

`default_nettype wire

// ===== rtl/core/escaped_line_frame_receiver.sv =====
// Top level of the escaped line frame receiver: front stage, frame store, response queue.
// A transferred request passes the front stage register and then a response queue slot
//   before its response shows.
// Throughput: one request per cycle while the queue has credit, set by the state update in the front.
// The front stalls only when the four-entry response queue has no credit left.
// Reset (synchronous): frame empty, escape clear, receiver armed, queue empty;
//   frame store contents are not cleared.
`default_nettype none

module escaped_line_frame_receiver
   import elfr_pkg::*;
#(
   parameter int BUF_DEPTH = DEF_BUF_DEPTH
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [MODE_W-1:0]      req_mode,
   input  wire logic [BYTE_W-1:0]      req_data_byte,
   input  wire logic [IDX_W-1:0]       req_read_index,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic [2:0]                  rsp_status,
   output logic [FRAME_LEN_W-1:0]      rsp_frame_length,
   output logic [BYTE_W-1:0]           rsp_read_byte
);

   // Store address width; fill count never exceeds BUF_DEPTH-1.
   localparam int ADDR_W = $clog2(BUF_DEPTH);

   // Store ports, driven straight from the front's classify logic.
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [BYTE_W-1:0] wr_data;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [BYTE_W-1:0] rd_data;

   // Front-to-back handoff; store read data lines up with s1_entry.
   logic              s1_valid;
   front_entry_type   s1_entry;
   logic              queue_room;

   elfr_front #(
      .BUF_DEPTH (BUF_DEPTH),
      .ADDR_W    (ADDR_W)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_mode       (req_mode),
      .req_data_byte  (req_data_byte),
      .req_read_index (req_read_index),
      .queue_room     (queue_room),
      .wr_en          (wr_en),
      .wr_addr        (wr_addr),
      .wr_data        (wr_data),
      .rd_en          (rd_en),
      .rd_addr        (rd_addr),
      .s1_valid       (s1_valid),
      .s1_entry       (s1_entry)
   );

   // Reads and link writes come from different transfers, so the ports never collide.
   elfr_store #(
      .BUF_DEPTH (BUF_DEPTH),
      .ADDR_W    (ADDR_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Back end: queue absorbs response stalls; once it has no credit left, the front stalls too.
   elfr_queue u_queue (
      .clock            (clock),
      .reset            (reset),
      .push             (s1_valid),
      .push_entry       (s1_entry),
      .rd_data          (rd_data),
      .room             (queue_room),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_frame_length (rsp_frame_length),
      .rsp_read_byte    (rsp_read_byte)
   );

endmodule

`default_nettype wire

// ===== rtl/core/elfr_store.sv =====
// Frame store memory: one write port, one registered read port.
`default_nettype none

module elfr_store
   import elfr_pkg::*;
#(
   parameter int BUF_DEPTH = DEF_BUF_DEPTH,
   parameter int ADDR_W    = $clog2(BUF_DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [BYTE_W-1:0] wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [BYTE_W-1:0] rd_data
);

   logic [BYTE_W-1:0] mem [BUF_DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/elfr_front.sv =====
// Front stage: accepts items, tracks framing state, drives the store ports.
`default_nettype none

module elfr_front
   import elfr_pkg::*;
#(
   parameter int BUF_DEPTH = DEF_BUF_DEPTH,
   parameter int ADDR_W    = $clog2(BUF_DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [MODE_W-1:0] req_mode,
   input  wire logic [BYTE_W-1:0] req_data_byte,
   input  wire logic [IDX_W-1:0]  req_read_index,
   input  wire logic              queue_room,
   output logic                   wr_en,
   output logic [ADDR_W-1:0]      wr_addr,
   output logic [BYTE_W-1:0]      wr_data,
   output logic                   rd_en,
   output logic [ADDR_W-1:0]      rd_addr,
   output logic                   s1_valid,
   output front_entry_type        s1_entry
);

   localparam int EXT_W = ((ADDR_W > IDX_W) ? ADDR_W : IDX_W) + 1;
   localparam logic [ADDR_W-1:0] FULL_COUNT = ADDR_W'(BUF_DEPTH - 1);

   logic [ADDR_W-1:0] fill_ff, fill_in;
   logic              esc_ff, esc_in;
   logic              ready_ff, ready_in;
   logic              s1_valid_ff;
   front_entry_type   s1_entry_ff;

   logic              accept;
   status_type        status;
   logic              link_wr;
   logic              in_range;
   logic [EXT_W-1:0]  idx_ext;
   logic [EXT_W-1:0]  fill_ext;

   assign req_stall = !queue_room;
   assign accept    = req_valid && queue_room;

   assign idx_ext  = EXT_W'(req_read_index);
   assign in_range = idx_ext < EXT_W'(BUF_DEPTH);

   always_comb begin
      fill_in  = fill_ff;
      esc_in   = esc_ff;
      ready_in = ready_ff;
      link_wr  = 1'b0;
      status   = ST_NOTREADY;
      unique case (req_mode)
         MODE_LINK: begin
            if (!ready_ff) begin
               status = ST_NOTREADY;
            end else if (!esc_ff && req_data_byte == CH_NEWLINE) begin
               ready_in = 1'b0;
               status   = ST_DONE;
            end else if (!esc_ff && req_data_byte == CH_RETURN) begin
               fill_in = '0;
               status  = ST_RESTART;
            end else if (!esc_ff && req_data_byte == CH_ESCAPE) begin
               esc_in = 1'b1;
               status = ST_ESC;
            end else if (fill_ff == FULL_COUNT) begin
               // store full: drop byte, restart frame, arm escape
               fill_in = '0;
               esc_in  = 1'b1;
               status  = ST_OVERFLOW;
            end else begin
               esc_in  = 1'b0;
               fill_in = fill_ff + 1'b1;
               link_wr = 1'b1;
               status  = ST_STORED;
            end
         end
         MODE_READ: begin
            status = ST_READ;
         end
         MODE_RELEASE: begin
            fill_in  = '0;
            esc_in   = 1'b0;
            ready_in = 1'b1;
            status   = ST_RELEASED;
         end
         default: begin
            status = ST_NOTREADY;
         end
      endcase
   end

   assign fill_ext = EXT_W'(fill_in);

   assign wr_en   = accept && link_wr;
   assign wr_addr = fill_ff;
   assign wr_data = req_data_byte;
   assign rd_en   = accept && (req_mode == MODE_READ) && in_range;
   assign rd_addr = idx_ext[ADDR_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff     <= '0;
         esc_ff      <= 1'b0;
         ready_ff    <= 1'b1;
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
         if (accept) begin
            fill_ff  <= fill_in;
            esc_ff   <= esc_in;
            ready_ff <= ready_in;
         end
      end
      if (accept) begin
         s1_entry_ff.status       <= status;
         s1_entry_ff.frame_length <= fill_ext[FRAME_LEN_W-1:0];
         s1_entry_ff.rd_en        <= (req_mode == MODE_READ) && in_range;
      end
   end

   assign s1_valid = s1_valid_ff;
   assign s1_entry = s1_entry_ff;

endmodule

`default_nettype wire

// ===== rtl/core/elfr_queue.sv =====
// Back end: response queue that merges read data and drives the result channel.
`default_nettype none

module elfr_queue
   import elfr_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    push,
   input  wire front_entry_type         push_entry,
   input  wire logic [BYTE_W-1:0]       rd_data,
   output logic                         room,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output logic [2:0]                   rsp_status,
   output logic [FRAME_LEN_W-1:0]       rsp_frame_length,
   output logic [BYTE_W-1:0]            rsp_read_byte
);

   rsp_entry_type       slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff;
   logic [QPTR_W-1:0]   rd_ptr_ff;
   logic [QCNT_W-1:0]   count_ff;
   logic [QCNT_W:0]     committed;
   logic                pop;
   rsp_entry_type       head;
   rsp_entry_type       new_entry;

   assign pop  = (count_ff != '0) && !rsp_stall;
   assign head = slot_ff[rd_ptr_ff];

   // credit covers the entry still sitting in the front stage
   assign committed = (QCNT_W + 1)'(count_ff) + (QCNT_W + 1)'(push);
   assign room      = committed < (QCNT_W + 1)'(QUEUE_DEPTH);

   always_comb begin
      new_entry.status       = push_entry.status;
      new_entry.frame_length = push_entry.frame_length;
      new_entry.read_byte    = push_entry.rd_en ? rd_data : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= new_entry;
      end
   end

   assign rsp_valid        = count_ff != '0;
   assign rsp_status       = head.status;
   assign rsp_frame_length = head.frame_length;
   assign rsp_read_byte    = head.read_byte;

endmodule

`default_nettype wire

// ===== rtl/core/elfr_checker.sv =====
// Port-level checker for the escaped line frame receiver, with its bind.
`default_nettype none

module elfr_checker
   import elfr_pkg::*;
(
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   rsp_valid,
   input wire logic                   rsp_stall,
   input wire logic [2:0]             rsp_status,
   input wire logic [FRAME_LEN_W-1:0] rsp_frame_length,
   input wire logic [BYTE_W-1:0]      rsp_read_byte
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response dropped while stalled");

   a_byte_only_on_read: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_READ |-> rsp_read_byte == '0)
      else $error("read byte nonzero on non-read response");

   a_empty_after_reset_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_RESTART || rsp_status == ST_OVERFLOW
                    || rsp_status == ST_RELEASED) |-> rsp_frame_length == '0)
      else $error("frame length not zero after restart, overflow or release");

   a_stored_nonempty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_STORED |-> rsp_frame_length != '0)
      else $error("stored byte reported with empty frame");

endmodule

bind escaped_line_frame_receiver elfr_checker u_elfr_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_status       (rsp_status),
   .rsp_frame_length (rsp_frame_length),
   .rsp_read_byte    (rsp_read_byte)
);

`default_nettype wire

// ===== tb/escaped_line_frame_receiver_tb.sv =====
// Self-checking testbench for the escaped line frame receiver: random and directed link traffic.
module escaped_line_frame_receiver_tb
   import elfr_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   // Mode 3 has no name in the package; the block must treat it as a no-op.
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
   // Most bytes the store may hold; one more data byte overflows.
   localparam int FILL_MAX = DEF_BUF_DEPTH - 1;
   // Requests to queue at the least, directed and random together.
   localparam int TOTAL_ITEMS = 1100;
   localparam int MAX_REPORTS = 100;

   // Receiver state as the link sees it: frame bytes, which entries were ever
   // written (reads of never-written entries must not be issued), fill level,
   // escape flag and whether new link bytes are taken.
   typedef struct packed {
      logic [DEF_BUF_DEPTH-1:0][BYTE_W-1:0] bytes;
      logic [DEF_BUF_DEPTH-1:0]             written;
      logic [FRAME_LEN_W-1:0]               fill;
      logic                                 esc;
      logic                                 armed;
   } frame_state_type;

   // One request as queued for the driver. drain_first holds the request back
   // until every outstanding response has come out.
   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [BYTE_W-1:0] data;
      logic [IDX_W-1:0]  index;
      logic              drain_first;
   } link_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [MODE_W-1:0]      req_mode = MODE_LINK;
   logic [BYTE_W-1:0]      req_data_byte = '0;
   logic [IDX_W-1:0]       req_read_index = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [2:0]             rsp_status;
   logic [FRAME_LEN_W-1:0] rsp_frame_length;
   logic [BYTE_W-1:0]      rsp_read_byte;

   link_item_type link_items[$];     // requests not yet transferred
   rsp_entry_type rsp_expected[$];   // predicted responses, oldest first

   frame_state_type plan_state;  // walked while building stimulus
   frame_state_type rx_state;    // walked on each accepted transfer

   bit          drain_next = 1'b0;
   int unsigned error_count = 0;

   // sender pacing
   int unsigned tx_gap = 0;
   int unsigned tx_calm = 0;
   // receiver pacing
   int unsigned rx_hold = 0;
   int unsigned rx_calm = 0;
   int unsigned results_seen = 0;
   int unsigned next_long_hold = 40;

   escaped_line_frame_receiver #(
      .BUF_DEPTH(DEF_BUF_DEPTH)
   ) u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_mode        (req_mode),
      .req_data_byte   (req_data_byte),
      .req_read_index  (req_read_index),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_frame_length(rsp_frame_length),
      .rsp_read_byte   (rsp_read_byte)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Prediction: advance the frame state by one request, return its response.
   // ------------------------------------------------------------------
   function automatic rsp_entry_type next_frame_result(inout frame_state_type st,
                                                       input logic [MODE_W-1:0] mode,
                                                       input logic [BYTE_W-1:0] b,
                                                       input logic [IDX_W-1:0] idx);
      rsp_entry_type r;
      r.status    = ST_NOTREADY;
      r.read_byte = '0;
      case (mode)
         MODE_LINK: begin
            // Control bytes act only when no escape is pending; after an
            // escape they fall through and are stored like any data byte.
            if (!st.armed) begin
               r.status = ST_NOTREADY;
            end else if (!st.esc && b == CH_NEWLINE) begin
               st.armed = 1'b0;
               r.status = ST_DONE;
            end else if (!st.esc && b == CH_RETURN) begin
               st.fill  = '0;
               r.status = ST_RESTART;
            end else if (!st.esc && b == CH_ESCAPE) begin
               st.esc   = 1'b1;
               r.status = ST_ESC;
            end else if (int'(st.fill) >= FILL_MAX) begin
               // full store: byte dropped, frame restarts with escape set
               st.fill  = '0;
               st.esc   = 1'b1;
               r.status = ST_OVERFLOW;
            end else begin
               st.esc               = 1'b0;
               st.bytes[st.fill]    = b;
               st.written[st.fill]  = 1'b1;
               st.fill              = st.fill + 1'b1;
               r.status             = ST_STORED;
            end
         end
         MODE_READ: begin
            if (int'(idx) < DEF_BUF_DEPTH) begin
               r.read_byte = st.bytes[idx];
            end
            r.status = ST_READ;
         end
         MODE_RELEASE: begin
            st.fill  = '0;
            st.esc   = 1'b0;
            st.armed = 1'b1;
            r.status = ST_RELEASED;
         end
         default: begin
            r.status = ST_NOTREADY;
         end
      endcase
      r.frame_length = st.fill;
      return r;
   endfunction

   // Idle length for either side: mostly none, sometimes short, rarely long.
   function automatic int unsigned pick_idle_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   function automatic logic [BYTE_W-1:0] pick_special();
      case ($urandom_range(0, 2))
         0:       return CH_NEWLINE;
         1:       return CH_RETURN;
         default: return CH_ESCAPE;
      endcase
   endfunction

   // Index of an entry that already holds a byte; favors the current frame.
   function automatic logic [IDX_W-1:0] pick_stored_index();
      logic [IDX_W-1:0] idx;
      if (plan_state.fill != 0 && $urandom_range(0, 1) == 0) begin
         return IDX_W'($urandom_range(0, int'(plan_state.fill) - 1));
      end
      for (int k = 0; k < 64; k++) begin
         idx = IDX_W'($urandom_range(0, DEF_BUF_DEPTH - 1));
         if (plan_state.written[idx]) return idx;
      end
      return '0;
   endfunction

   // ------------------------------------------------------------------
   // Stimulus building
   // ------------------------------------------------------------------
   task automatic queue_item(input logic [MODE_W-1:0] mode, input logic [BYTE_W-1:0] b,
                             input logic [IDX_W-1:0] idx);
      link_item_type it;
      void'(next_frame_result(plan_state, mode, b, idx));
      it.mode        = mode;
      it.data        = b;
      it.index       = idx;
      it.drain_first = drain_next;
      drain_next     = 1'b0;
      link_items.push_back(it);
   endtask

   // Unused fields carry random values so the block is seen to ignore them.
   task automatic queue_link(input logic [BYTE_W-1:0] b);
      queue_item(MODE_LINK, b, IDX_W'($urandom_range(0, DEF_BUF_DEPTH - 1)));
   endtask

   task automatic queue_read();
      queue_item(MODE_READ, BYTE_W'($urandom_range(0, 255)), pick_stored_index());
   endtask

   task automatic queue_release();
      queue_item(MODE_RELEASE, BYTE_W'($urandom_range(0, 255)),
                 IDX_W'($urandom_range(0, DEF_BUF_DEPTH - 1)));
   endtask

   // A data byte of a well-formed frame: control values go out escaped.
   task automatic queue_body_byte(input logic [BYTE_W-1:0] b);
      if (b == CH_NEWLINE || b == CH_RETURN || b == CH_ESCAPE) queue_link(CH_ESCAPE);
      queue_link(b);
   endtask

   // Well-formed transfer sequence: frame body, newline, a few reads, maybe a refused link byte, release.
   task automatic queue_frame();
      int unsigned r;
      int unsigned len;
      r = $urandom_range(0, 99);
      if (r < 80)      len = $urandom_range(0, 12);
      else if (r < 98) len = $urandom_range(13, 40);
      else             len = $urandom_range(41, 120);
      for (int i = 0; i < int'(len); i++) begin
         if ($urandom_range(0, 19) == 0) queue_body_byte(pick_special());
         else                            queue_body_byte(BYTE_W'($urandom_range(0, 255)));
         // occasional carriage return throws the partial frame away
         if ($urandom_range(0, 29) == 0) queue_link(CH_RETURN);
      end
      queue_link(CH_NEWLINE);
      repeat ($urandom_range(0, 3)) queue_read();
      // link bytes while the frame waits for release are refused
      if ($urandom_range(0, 9) < 3) queue_link(BYTE_W'($urandom_range(0, 255)));
      queue_release();
   endtask

   task automatic build_stimulus();
      int unsigned r;

      // --- directed: escapes, restart, done, not-ready, releases ---
      queue_link(8'h41);
      queue_link(8'h00);
      queue_link(8'hFF);
      queue_link(CH_ESCAPE);       // escaped newline is data
      queue_link(CH_NEWLINE);
      queue_link(CH_ESCAPE);       // escaped return is data
      queue_link(CH_RETURN);
      queue_link(CH_ESCAPE);       // escaped escape is data
      queue_link(CH_ESCAPE);
      queue_read();
      queue_item(MODE_READ, 8'h00, 10'd5);
      queue_item(MODE_UNUSED, 8'hFF, 10'h3FF);
      queue_link(CH_RETURN);       // partial frame dropped
      queue_link(8'h7E);
      queue_link(CH_ESCAPE);
      queue_release();             // release mid-frame also clears the escape
      queue_link(CH_NEWLINE);      // empty frame done
      queue_link(8'h33);           // refused until release
      queue_link(CH_ESCAPE);
      queue_item(MODE_READ, 8'h5A, 10'd0);
      queue_release();
      queue_release();
      queue_link(8'h5A);
      queue_link(CH_NEWLINE);
      drain_next = 1'b1;           // sender waits for all responses here
      queue_release();

      // --- one full frame: fill to the top, then overflow ---
      drain_next = 1'b1;
      while (int'(plan_state.fill) < FILL_MAX) begin
         queue_body_byte(BYTE_W'($urandom_range(0, 255)));
      end
      queue_item(MODE_READ, 8'h00, 10'(FILL_MAX - 1));
      queue_item(MODE_READ, 8'h00, 10'd511);
      queue_item(MODE_READ, 8'h00, 10'd512);
      queue_link(CH_ESCAPE);       // escape byte at full store is still an escape
      queue_link(8'hA5);           // overflow: dropped, escape left set
      queue_link(CH_NEWLINE);      // taken as data because of that escape
      queue_link(CH_NEWLINE);
      queue_release();

      // --- random: mostly well-formed frames, some noise ---
      drain_next = 1'b1;
      while (link_items.size() < TOTAL_ITEMS) begin
         r = $urandom_range(0, 99);
         if (r < 3) drain_next = 1'b1;
         if (r < 70) begin
            queue_frame();
         end else if (r < 80) begin
            queue_read();
         end else if (r < 86) begin
            queue_item(MODE_UNUSED, BYTE_W'($urandom_range(0, 255)),
                       IDX_W'($urandom_range(0, DEF_BUF_DEPTH - 1)));
         end else if (r < 93) begin
            queue_release();
         end else begin
            // raw byte, control values unescaped
            if ($urandom_range(0, 1) == 0) queue_link(pick_special());
            else                           queue_link(BYTE_W'($urandom_range(0, 255)));
         end
      end
   endtask

   // ------------------------------------------------------------------
   // Driver: presents the queued requests; predicts on each transfer.
   // ------------------------------------------------------------------
   always @(posedge clock) begin : link_driver
      rsp_entry_type want;
      if (reset) begin
         req_valid        <= 1'b0;
         rx_state.bytes   = '0;
         rx_state.written = '0;
         rx_state.fill    = '0;
         rx_state.esc     = 1'b0;
         rx_state.armed   = 1'b1;
      end else begin
         if (req_valid && !req_stall) begin
            want = next_frame_result(rx_state, req_mode, req_data_byte, req_read_index);
            rsp_expected.push_back(want);
            void'(link_items.pop_front());
            tx_gap = (tx_calm != 0) ? 0 : pick_idle_len();
         end
         // calm stretches: no gaps at all for a while
         if (tx_calm != 0) tx_calm--;
         else if ($urandom_range(0, 199) == 0) tx_calm = $urandom_range(50, 150);

         // a stalled transfer keeps its payload; otherwise pick what comes next
         if (!(req_valid && req_stall)) begin
            if (tx_gap != 0) begin
               tx_gap--;
               req_valid <= 1'b0;
            end else if (link_items.size() == 0 ||
                         (link_items[0].drain_first && rsp_expected.size() != 0)) begin
               req_valid <= 1'b0;
            end else begin
               req_valid      <= 1'b1;
               req_mode       <= link_items[0].mode;
               req_data_byte  <= link_items[0].data;
               req_read_index <= link_items[0].index;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Monitor: checks each response transfer, paces rsp_stall.
   // ------------------------------------------------------------------
   task automatic report_mismatch(input string field, input int unsigned want_v,
                                  input int unsigned got_v);
      error_count++;
      // keep the log readable when a bug floods it
      if (error_count <= MAX_REPORTS) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want_v, got_v);
      end
   endtask

   always @(posedge clock) begin : rsp_monitor
      rsp_entry_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (rsp_expected.size() == 0) begin
               report_mismatch("unexpected response, status", 0, 32'(rsp_status));
            end else begin
               want = rsp_expected.pop_front();
               if (rsp_status !== want.status)
                  report_mismatch("status", 32'(want.status), 32'(rsp_status));
               if (rsp_frame_length !== want.frame_length)
                  report_mismatch("frame_length", 32'(want.frame_length),
                                  32'(rsp_frame_length));
               if (rsp_read_byte !== want.read_byte)
                  report_mismatch("read_byte", 32'(want.read_byte), 32'(rsp_read_byte));
            end
         end

         if (rx_calm != 0) rx_calm--;
         else if ($urandom_range(0, 199) == 0) rx_calm = $urandom_range(50, 150);

         if (rx_hold != 0) begin
            rx_stall_hold: begin
               rx_hold--;
               rsp_stall <= 1'b1;
            end
         end else if (results_seen >= next_long_hold) begin
            // long back-pressure: the response queue fills and req_stall rises
            next_long_hold = results_seen + 500;
            rx_hold = 59;
            rsp_stall <= 1'b1;
         end else if (rx_calm != 0) begin
            rsp_stall <= 1'b0;
         end else begin
            rx_hold = pick_idle_len();
            if (rx_hold == 0) begin
               rsp_stall <= 1'b0;
            end else begin
               rx_hold--;
               rsp_stall <= 1'b1;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Run control
   // ------------------------------------------------------------------
   initial begin : run_control
      plan_state.bytes   = '0;
      plan_state.written = '0;
      plan_state.fill    = '0;
      plan_state.esc     = 1'b0;
      plan_state.armed   = 1'b1;
      build_stimulus();

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (link_items.size() != 0 || rsp_expected.size() != 0) @(posedge clock);
      // catch any stray response still on its way
      repeat (100) @(posedge clock);

      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin : watchdog
      #2_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/elfr_pkg.sv
rtl/core/elfr_store.sv
rtl/core/elfr_front.sv
rtl/core/elfr_queue.sv
rtl/core/escaped_line_frame_receiver.sv
rtl/core/elfr_checker.sv
tb/escaped_line_frame_receiver_tb.sv
